### src/wheel_fault_monitor_assert.svh
// Assertion macros shared by the wheel fault monitor RTL.
`ifndef WHEEL_FAULT_MONITOR_ASSERT_SVH
`define WHEEL_FAULT_MONITOR_ASSERT_SVH

// Same-cycle implication, checked on i_clk outside reset.
`define WFM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on i_clk outside reset.
`define WFM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/wfm_pkg.sv
// Types and constants of the wheel fault monitor.
package wfm_pkg;

    localparam int unsigned WHEELS   = 4;
    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned MAG_W    = SAMPLE_W + 1;
    localparam int unsigned THRESH_W = 15;
    localparam int unsigned MS_W     = 16;
    localparam int unsigned TIME_W   = 32;
    localparam int unsigned REASON_W = 2;
    localparam int unsigned INDEX_W  = 3;
    localparam int unsigned VALUE_W  = 16;

    // Item operations
    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_RESET  = 1'b1;

    // Fault reasons
    localparam logic [REASON_W-1:0] REASON_NONE    = 2'd0;
    localparam logic [REASON_W-1:0] REASON_RUNAWAY = 2'd1;
    localparam logic [REASON_W-1:0] REASON_STUCK   = 2'd2;

    // Register indexes
    localparam logic [INDEX_W-1:0] REG_MONITOR_ENABLE   = 3'd0;
    localparam logic [INDEX_W-1:0] REG_TARGET_NEAR_ZERO = 3'd1;
    localparam logic [INDEX_W-1:0] REG_SPEED_RUNAWAY    = 3'd2;
    localparam logic [INDEX_W-1:0] REG_TARGET_ACTIVE    = 3'd3;
    localparam logic [INDEX_W-1:0] REG_SPEED_STUCK      = 3'd4;
    localparam logic [INDEX_W-1:0] REG_SUSPECT_MS       = 3'd5;
    localparam logic [INDEX_W-1:0] REG_CLEAR_MS         = 3'd6;

    // Register reset values
    localparam logic                RST_MONITOR_ENABLE   = 1'b1;
    localparam logic [THRESH_W-1:0] RST_TARGET_NEAR_ZERO = 15'd128;
    localparam logic [THRESH_W-1:0] RST_SPEED_RUNAWAY    = 15'd2048;
    localparam logic [THRESH_W-1:0] RST_TARGET_ACTIVE    = 15'd1024;
    localparam logic [THRESH_W-1:0] RST_SPEED_STUCK      = 15'd128;
    localparam logic [MS_W-1:0]     RST_SUSPECT_MS       = 16'd500;
    localparam logic [MS_W-1:0]     RST_CLEAR_MS         = 16'd2000;

    typedef enum logic [2:0] {
        MODE_NORMAL  = 3'b001,
        MODE_SUSPECT = 3'b010,
        MODE_FAULT   = 3'b100
    } t_mode;

    typedef struct packed {
        logic                       op;
        logic [TIME_W-1:0]          now_ms;
        logic signed [SAMPLE_W-1:0] target_fl;
        logic signed [SAMPLE_W-1:0] target_rl;
        logic signed [SAMPLE_W-1:0] target_fr;
        logic signed [SAMPLE_W-1:0] target_rr;
        logic signed [SAMPLE_W-1:0] speed_fl;
        logic signed [SAMPLE_W-1:0] speed_rl;
        logic signed [SAMPLE_W-1:0] speed_fr;
        logic signed [SAMPLE_W-1:0] speed_rr;
    } t_in_item;

    typedef struct packed {
        logic [WHEELS-1:0]   fault_mask;
        logic [WHEELS-1:0]   enable_mask;
        logic [WHEELS-1:0]   pid_clear_mask;
        logic                critical;
        logic [REASON_W-1:0] reason_fl;
        logic [REASON_W-1:0] reason_rl;
        logic [REASON_W-1:0] reason_fr;
        logic [REASON_W-1:0] reason_rr;
    } t_out_item;

    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic [VALUE_W-1:0] value;
    } t_cfg_beat;

    // Settings seen by every lane
    typedef struct packed {
        logic                enable;
        logic [THRESH_W-1:0] target_near_zero;
        logic [THRESH_W-1:0] speed_runaway;
        logic [THRESH_W-1:0] target_active;
        logic [THRESH_W-1:0] speed_stuck;
        logic [MS_W-1:0]     suspect_ms;
        logic [MS_W-1:0]     clear_ms;
    } t_settings;

    // Per-wheel state after the current beat
    typedef struct packed {
        logic                fault;
        logic                enable;
        logic                pid_clear;
        logic [REASON_W-1:0] reason;
    } t_lane_stat;

endpackage

### src/wfm_chan_if.sv
// Valid/ready channel carrying one payload beat.
interface wfm_chan_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### src/wheel_fault_monitor.sv
// Wheel fault monitor top level: settings registers, four wheel lanes, merge.
//
// Channels: i_in takes one item per beat (update with samples, or reset of all
// wheels); o_out gives exactly one result beat per item, in order; i_cfg
// writes one settings register per beat and is always ready. Write settings
// only while no result is outstanding.
// Latency: the result of an item is valid in the cycle after it is accepted.
// Throughput: one item per cycle while o_out.ready stays high. The four wheels are checked side by side,
// each in its own lane with a combinational compare and timer subtraction,
// and the merge stage holds one result register.
// When the receiver stalls, the held result stays put and i_in.ready follows
// o_out.ready, so a new item is accepted in the same cycle the old result
// leaves.
// Reset (i_rst_n low, synchronous): every wheel returns to normal with motor
// enabled and no reason, settings take their default values, and the result
// register is emptied. No clearing pass is needed.
module wheel_fault_monitor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    wfm_chan_if.sink    i_in,
    wfm_chan_if.source  o_out,
    wfm_chan_if.sink    i_cfg
);

    wfm_pkg::t_settings                         r_set;
    wfm_pkg::t_in_item                          in_item;
    wfm_pkg::t_cfg_beat                         cfg_beat;
    wfm_pkg::t_lane_stat [wfm_pkg::WHEELS-1:0]  stat;
    logic signed [wfm_pkg::SAMPLE_W-1:0]        target [wfm_pkg::WHEELS];
    logic signed [wfm_pkg::SAMPLE_W-1:0]        speed  [wfm_pkg::WHEELS];
    logic                                       can_take;
    logic                                       fire;

    assign in_item  = i_in.data;
    assign cfg_beat = i_cfg.data;

    assign i_in.ready  = can_take;
    assign fire        = i_in.valid && can_take;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set.enable           <= wfm_pkg::RST_MONITOR_ENABLE;
            r_set.target_near_zero <= wfm_pkg::RST_TARGET_NEAR_ZERO;
            r_set.speed_runaway    <= wfm_pkg::RST_SPEED_RUNAWAY;
            r_set.target_active    <= wfm_pkg::RST_TARGET_ACTIVE;
            r_set.speed_stuck      <= wfm_pkg::RST_SPEED_STUCK;
            r_set.suspect_ms       <= wfm_pkg::RST_SUSPECT_MS;
            r_set.clear_ms         <= wfm_pkg::RST_CLEAR_MS;
        end else if (i_cfg.valid) begin
            case (cfg_beat.index)
                wfm_pkg::REG_MONITOR_ENABLE:
                    r_set.enable <= cfg_beat.value[0];
                wfm_pkg::REG_TARGET_NEAR_ZERO:
                    r_set.target_near_zero <= cfg_beat.value[wfm_pkg::THRESH_W-1:0];
                wfm_pkg::REG_SPEED_RUNAWAY:
                    r_set.speed_runaway <= cfg_beat.value[wfm_pkg::THRESH_W-1:0];
                wfm_pkg::REG_TARGET_ACTIVE:
                    r_set.target_active <= cfg_beat.value[wfm_pkg::THRESH_W-1:0];
                wfm_pkg::REG_SPEED_STUCK:
                    r_set.speed_stuck <= cfg_beat.value[wfm_pkg::THRESH_W-1:0];
                wfm_pkg::REG_SUSPECT_MS:
                    r_set.suspect_ms <= cfg_beat.value[wfm_pkg::MS_W-1:0];
                wfm_pkg::REG_CLEAR_MS:
                    r_set.clear_ms <= cfg_beat.value[wfm_pkg::MS_W-1:0];
                default: begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    // Lane order matches mask bit order: fl, rl, fr, rr
    assign target[0] = in_item.target_fl;
    assign target[1] = in_item.target_rl;
    assign target[2] = in_item.target_fr;
    assign target[3] = in_item.target_rr;
    assign speed[0]  = in_item.speed_fl;
    assign speed[1]  = in_item.speed_rl;
    assign speed[2]  = in_item.speed_fr;
    assign speed[3]  = in_item.speed_rr;

    for (genvar g = 0; g < wfm_pkg::WHEELS; g++) begin : g_lane
        wfm_lane u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_fire   (fire),
            .i_op     (in_item.op),
            .i_set    (r_set),
            .i_now_ms (in_item.now_ms),
            .i_target (target[g]),
            .i_speed  (speed[g]),
            .o_stat   (stat[g])
        );
    end

    wfm_merge u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (fire),
        .i_stat     (stat),
        .o_can_take (can_take),
        .o_out      (o_out)
    );

`include "wheel_fault_monitor_assert.svh"

    `WFM_ASSERT_NOW(a_critical_count, o_out.valid, o_out.data.critical == ($countones(o_out.data.fault_mask) >= 2), "critical flag disagrees with fault mask")
    `WFM_ASSERT_NOW(a_pid_in_fault, o_out.valid, (o_out.data.pid_clear_mask & ~o_out.data.fault_mask) == 4'b0000, "PID clear pulse on a wheel not in fault")
    `WFM_ASSERT_NOW(a_enable_fault, o_out.valid, o_out.data.enable_mask == ~o_out.data.fault_mask, "motor enabled on a faulted wheel")
    `WFM_ASSERT_NEXT(a_reset_item, i_in.valid && i_in.ready && (i_in.data.op == wfm_pkg::OP_RESET), o_out.valid && (o_out.data.fault_mask == 4'b0000) && (o_out.data.pid_clear_mask == 4'b0000), "reset item left a wheel faulted")

endmodule

### src/wfm_lane.sv
// One wheel: condition check and normal/suspect/fault state machine.
module wfm_lane (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_fire,
    input  logic                                        i_op,
    input  wfm_pkg::t_settings                          i_set,
    input  logic [wfm_pkg::TIME_W-1:0]                  i_now_ms,
    input  logic signed [wfm_pkg::SAMPLE_W-1:0]         i_target,
    input  logic signed [wfm_pkg::SAMPLE_W-1:0]         i_speed,
    output wfm_pkg::t_lane_stat                         o_stat
);

    wfm_pkg::t_mode                     r_mode, n_mode;
    logic [wfm_pkg::TIME_W-1:0]         r_timer, n_timer;
    logic [wfm_pkg::REASON_W-1:0]       r_reason, n_reason;
    logic                               r_enable, n_enable;
    logic                               pid_clear;

    logic [wfm_pkg::MAG_W-1:0]          t_ext, s_ext, t_mag, s_mag;
    logic                               runaway, stuck, now_bad;
    logic [wfm_pkg::TIME_W-1:0]         elapsed;
    logic                               suspect_done, clear_done;

    // Exact magnitudes: the most negative sample maps to 2^15
    assign t_ext = {i_target[wfm_pkg::SAMPLE_W-1], i_target};
    assign s_ext = {i_speed[wfm_pkg::SAMPLE_W-1], i_speed};
    assign t_mag = i_target[wfm_pkg::SAMPLE_W-1] ? (~t_ext + 1'b1) : t_ext;
    assign s_mag = i_speed[wfm_pkg::SAMPLE_W-1] ? (~s_ext + 1'b1) : s_ext;

    assign runaway = (t_mag < wfm_pkg::MAG_W'(i_set.target_near_zero))
                  && (s_mag > wfm_pkg::MAG_W'(i_set.speed_runaway));
    assign stuck   = (t_mag > wfm_pkg::MAG_W'(i_set.target_active))
                  && (s_mag < wfm_pkg::MAG_W'(i_set.speed_stuck));
    assign now_bad = runaway || stuck;

    // Wrapping difference
    assign elapsed      = i_now_ms - r_timer;
    assign suspect_done = elapsed >= wfm_pkg::TIME_W'(i_set.suspect_ms);
    assign clear_done   = elapsed >= wfm_pkg::TIME_W'(i_set.clear_ms);

    always_comb begin
        n_mode    = r_mode;
        n_timer   = r_timer;
        n_reason  = r_reason;
        n_enable  = r_enable;
        pid_clear = 1'b0;
        if (i_fire) begin
            if (i_op == wfm_pkg::OP_RESET) begin
                n_mode   = wfm_pkg::MODE_NORMAL;
                n_timer  = '0;
                n_reason = wfm_pkg::REASON_NONE;
                n_enable = 1'b1;
            end else if (i_set.enable) begin
                case (r_mode)
                    wfm_pkg::MODE_SUSPECT: begin
                        if (!now_bad) begin
                            n_mode = wfm_pkg::MODE_NORMAL;
                        end else if (suspect_done) begin
                            n_mode    = wfm_pkg::MODE_FAULT;
                            n_reason  = runaway ? wfm_pkg::REASON_RUNAWAY
                                                : wfm_pkg::REASON_STUCK;
                            n_enable  = 1'b0;
                            pid_clear = 1'b1;
                        end
                    end
                    wfm_pkg::MODE_FAULT: begin
                        // Any sighting of the condition restarts the clear window
                        if (now_bad) begin
                            n_timer = i_now_ms;
                        end else if (clear_done) begin
                            n_mode   = wfm_pkg::MODE_NORMAL;
                            n_reason = wfm_pkg::REASON_NONE;
                            n_enable = 1'b1;
                        end
                    end
                    default: begin
                        n_mode = wfm_pkg::MODE_NORMAL;
                        if (now_bad) begin
                            n_mode  = wfm_pkg::MODE_SUSPECT;
                            n_timer = i_now_ms;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= wfm_pkg::MODE_NORMAL;
            r_timer  <= '0;
            r_reason <= wfm_pkg::REASON_NONE;
            r_enable <= 1'b1;
        end else begin
            r_mode   <= n_mode;
            r_timer  <= n_timer;
            r_reason <= n_reason;
            r_enable <= n_enable;
        end
    end

    assign o_stat.fault     = (n_mode == wfm_pkg::MODE_FAULT);
    assign o_stat.enable    = n_enable;
    assign o_stat.pid_clear = pid_clear;
    assign o_stat.reason    = n_reason;

endmodule

### src/wfm_merge.sv
// Merge of the four lane results into one registered result beat.
module wfm_merge (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_load,
    input  wfm_pkg::t_lane_stat [wfm_pkg::WHEELS-1:0] i_stat,
    output logic                                    o_can_take,
    wfm_chan_if.source                              o_out
);

    logic                           r_valid;
    wfm_pkg::t_out_item             r_item;
    wfm_pkg::t_out_item             n_item;
    logic [wfm_pkg::WHEELS-1:0]     fault_m, en_m, pid_m;
    logic [2:0]                     count;

    always_comb begin
        count = '0;
        for (int i = 0; i < wfm_pkg::WHEELS; i++) begin
            fault_m[i] = i_stat[i].fault;
            en_m[i]    = i_stat[i].enable;
            pid_m[i]   = i_stat[i].pid_clear;
            count      = count + {2'b00, i_stat[i].fault};
        end
    end

    always_comb begin
        n_item.fault_mask     = fault_m;
        n_item.enable_mask    = en_m;
        n_item.pid_clear_mask = pid_m;
        n_item.critical       = (count >= 3'd2);
        n_item.reason_fl      = i_stat[0].reason;
        n_item.reason_rl      = i_stat[1].reason;
        n_item.reason_fr      = i_stat[2].reason;
        n_item.reason_rr      = i_stat[3].reason;
    end

    // Take a new beat when empty or when the held one leaves this cycle
    assign o_can_take = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= n_item;
        end
    end

    assign o_out.valid = r_valid;
    assign o_out.data  = r_item;

endmodule

### test/wheel_fault_monitor_tb.sv
// Self-checking testbench for the wheel fault monitor: directed and random traffic.
`timescale 1ns / 1ps

module wheel_fault_monitor_tb;

    localparam logic [wfm_pkg::INDEX_W-1:0] REG_UNUSED = 3'd7;
    localparam int unsigned                 REG_COUNT  = 7;

    logic i_clk;
    logic i_rst_n;

    wfm_chan_if #(.t_payload(wfm_pkg::t_in_item))  in_ch ();
    wfm_chan_if #(.t_payload(wfm_pkg::t_out_item)) out_ch ();
    wfm_chan_if #(.t_payload(wfm_pkg::t_cfg_beat)) cfg_ch ();

    wheel_fault_monitor uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // Mirror of the block's settings and per-wheel state
    wfm_pkg::t_settings           shadow_settings;
    wfm_pkg::t_mode               wheel_mode   [wfm_pkg::WHEELS];
    logic [wfm_pkg::TIME_W-1:0]   wheel_timer  [wfm_pkg::WHEELS];
    logic [wfm_pkg::REASON_W-1:0] wheel_reason [wfm_pkg::WHEELS];
    logic                         motor_on     [wfm_pkg::WHEELS];

    wfm_pkg::t_out_item awaited_status [$];
    int unsigned        mismatch_count;

    // Sender and receiver pacing
    int unsigned burst_left;
    bit          gaps_enabled;
    int unsigned hold_cycles_req;

    // Random traffic state
    logic [wfm_pkg::TIME_W-1:0]   sim_now;
    bit                           wheel_bad  [wfm_pkg::WHEELS];
    logic [wfm_pkg::REASON_W-1:0] wheel_kind [wfm_pkg::WHEELS];

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("wheel_fault_monitor_tb: errors");
        $finish;
    end

    function automatic void clear_wheels();
        for (int i = 0; i < wfm_pkg::WHEELS; i++) begin
            wheel_mode[i]   = wfm_pkg::MODE_NORMAL;
            wheel_timer[i]  = '0;
            wheel_reason[i] = wfm_pkg::REASON_NONE;
            motor_on[i]     = 1'b1;
        end
    endfunction

    function automatic int unsigned magnitude(logic signed [wfm_pkg::SAMPLE_W-1:0] v);
        return (v < 0) ? -int'(v) : int'(v);
    endfunction

    // Advance the wheel mirror by one item and return the status it should produce
    function automatic wfm_pkg::t_out_item advance_wheels(wfm_pkg::t_in_item item);
        logic signed [wfm_pkg::SAMPLE_W-1:0] tg [wfm_pkg::WHEELS];
        logic signed [wfm_pkg::SAMPLE_W-1:0] sp [wfm_pkg::WHEELS];
        int unsigned t_mag, s_mag, faulted;
        logic runaway, stuck;
        logic [wfm_pkg::TIME_W-1:0] elapsed;
        wfm_pkg::t_out_item res;
        res = '0;
        faulted = 0;
        tg = '{item.target_fl, item.target_rl, item.target_fr, item.target_rr};
        sp = '{item.speed_fl, item.speed_rl, item.speed_fr, item.speed_rr};
        if (item.op == wfm_pkg::OP_RESET) begin
            clear_wheels();
        end else if (shadow_settings.enable) begin
            for (int i = 0; i < wfm_pkg::WHEELS; i++) begin
                t_mag   = magnitude(tg[i]);
                s_mag   = magnitude(sp[i]);
                runaway = (t_mag < shadow_settings.target_near_zero) &&
                          (s_mag > shadow_settings.speed_runaway);
                stuck   = (t_mag > shadow_settings.target_active) &&
                          (s_mag < shadow_settings.speed_stuck);
                elapsed = item.now_ms - wheel_timer[i];
                case (wheel_mode[i])
                    wfm_pkg::MODE_SUSPECT: begin
                        if (!(runaway || stuck)) begin
                            wheel_mode[i] = wfm_pkg::MODE_NORMAL;
                        end else if (elapsed >= shadow_settings.suspect_ms) begin
                            wheel_mode[i]      = wfm_pkg::MODE_FAULT;
                            wheel_reason[i]    = runaway ? wfm_pkg::REASON_RUNAWAY
                                                         : wfm_pkg::REASON_STUCK;
                            motor_on[i]        = 1'b0;
                            res.pid_clear_mask[i] = 1'b1;
                        end
                    end
                    wfm_pkg::MODE_FAULT: begin
                        // a fault persisting keeps pushing the recovery window out
                        if (runaway || stuck) begin
                            wheel_timer[i] = item.now_ms;
                        end else if (elapsed >= shadow_settings.clear_ms) begin
                            wheel_mode[i]   = wfm_pkg::MODE_NORMAL;
                            wheel_reason[i] = wfm_pkg::REASON_NONE;
                            motor_on[i]     = 1'b1;
                        end
                    end
                    default: begin
                        wheel_mode[i] = wfm_pkg::MODE_NORMAL;
                        if (runaway || stuck) begin
                            wheel_mode[i]  = wfm_pkg::MODE_SUSPECT;
                            wheel_timer[i] = item.now_ms;
                        end
                    end
                endcase
            end
        end
        for (int i = 0; i < wfm_pkg::WHEELS; i++) begin
            res.fault_mask[i]  = (wheel_mode[i] == wfm_pkg::MODE_FAULT);
            res.enable_mask[i] = motor_on[i];
            if (wheel_mode[i] == wfm_pkg::MODE_FAULT) faulted++;
        end
        res.critical  = (faulted >= 2);
        res.reason_fl = wheel_reason[0];
        res.reason_rl = wheel_reason[1];
        res.reason_fr = wheel_reason[2];
        res.reason_rr = wheel_reason[3];
        return res;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin : scoreboard
        wfm_pkg::t_out_item want, got;
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                got = out_ch.data;
                if (awaited_status.size() == 0) begin
                    $display("%0t: status beat with nothing outstanding", $time);
                    mismatch_count++;
                end else begin
                    want = awaited_status.pop_front();
                    check_field("fault_mask", want.fault_mask, got.fault_mask);
                    check_field("enable_mask", want.enable_mask, got.enable_mask);
                    check_field("pid_clear_mask", want.pid_clear_mask, got.pid_clear_mask);
                    check_field("critical", want.critical, got.critical);
                    check_field("reason_fl", want.reason_fl, got.reason_fl);
                    check_field("reason_rl", want.reason_rl, got.reason_rl);
                    check_field("reason_fr", want.reason_fr, got.reason_fr);
                    check_field("reason_rr", want.reason_rr, got.reason_rr);
                end
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (cfg_ch.data.index)
                    wfm_pkg::REG_MONITOR_ENABLE:
                        shadow_settings.enable = cfg_ch.data.value[0];
                    wfm_pkg::REG_TARGET_NEAR_ZERO:
                        shadow_settings.target_near_zero =
                            cfg_ch.data.value[wfm_pkg::THRESH_W-1:0];
                    wfm_pkg::REG_SPEED_RUNAWAY:
                        shadow_settings.speed_runaway =
                            cfg_ch.data.value[wfm_pkg::THRESH_W-1:0];
                    wfm_pkg::REG_TARGET_ACTIVE:
                        shadow_settings.target_active =
                            cfg_ch.data.value[wfm_pkg::THRESH_W-1:0];
                    wfm_pkg::REG_SPEED_STUCK:
                        shadow_settings.speed_stuck =
                            cfg_ch.data.value[wfm_pkg::THRESH_W-1:0];
                    wfm_pkg::REG_SUSPECT_MS:
                        shadow_settings.suspect_ms = cfg_ch.data.value;
                    wfm_pkg::REG_CLEAR_MS:
                        shadow_settings.clear_ms = cfg_ch.data.value;
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready) begin
                awaited_status.push_back(advance_wheels(in_ch.data));
            end
        end
    end

    // Receiver: stall rate drawn afresh after each random-length run, plus requested long holds
    initial begin : receiver
        int unsigned stall_pct, pattern_left, hold_left;
        stall_pct    = 0;
        pattern_left = 0;
        hold_left    = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_cycles_req != 0) begin
                hold_left       = hold_cycles_req;
                hold_cycles_req = 0;
            end
            if (hold_left != 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                if (pattern_left == 0) begin
                    case ($urandom_range(0, 4))
                        0, 1:    stall_pct = 0;
                        2:       stall_pct = 25;
                        3:       stall_pct = 50;
                        default: stall_pct = 85;
                    endcase
                    pattern_left = $urandom_range(20, 80);
                end
                pattern_left--;
                out_ch.ready <= ($urandom_range(1, 100) > stall_pct);
            end
        end
    end

    task automatic send_item(input wfm_pkg::t_in_item item);
        int unsigned gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (gaps_enabled && $urandom_range(0, 2) != 0) gap = $urandom_range(1, 6);
        end
        burst_left--;
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= item;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    task automatic send_samples(input logic op, input logic [wfm_pkg::TIME_W-1:0] now,
                                input int tfl, input int trl, input int tfr, input int trr,
                                input int sfl, input int srl, input int sfr, input int srr);
        wfm_pkg::t_in_item item;
        item.op        = op;
        item.now_ms    = now;
        item.target_fl = wfm_pkg::SAMPLE_W'(tfl);
        item.target_rl = wfm_pkg::SAMPLE_W'(trl);
        item.target_fr = wfm_pkg::SAMPLE_W'(tfr);
        item.target_rr = wfm_pkg::SAMPLE_W'(trr);
        item.speed_fl  = wfm_pkg::SAMPLE_W'(sfl);
        item.speed_rl  = wfm_pkg::SAMPLE_W'(srl);
        item.speed_fr  = wfm_pkg::SAMPLE_W'(sfr);
        item.speed_rr  = wfm_pkg::SAMPLE_W'(srr);
        send_item(item);
    endtask

    // Drop valid, then wait for every outstanding status beat to come back
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do @(negedge i_clk); while (awaited_status.size() != 0);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_registers(input logic [wfm_pkg::VALUE_W-1:0] vals [REG_COUNT],
                                   input bit poke_unused);
        logic [wfm_pkg::INDEX_W-1:0] order [REG_COUNT];
        order = '{wfm_pkg::REG_MONITOR_ENABLE, wfm_pkg::REG_TARGET_NEAR_ZERO,
                  wfm_pkg::REG_SPEED_RUNAWAY, wfm_pkg::REG_TARGET_ACTIVE,
                  wfm_pkg::REG_SPEED_STUCK, wfm_pkg::REG_SUSPECT_MS, wfm_pkg::REG_CLEAR_MS};
        for (int i = 0; i < REG_COUNT; i++) begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.data  <= '{index: order[i], value: vals[i]};
            @(posedge i_clk);
            while (!cfg_ch.ready) @(posedge i_clk);
        end
        // an index past the register list must leave everything alone
        if (poke_unused) begin
            cfg_ch.data <= '{index: REG_UNUSED, value: wfm_pkg::VALUE_W'($urandom)};
            @(posedge i_clk);
            while (!cfg_ch.ready) @(posedge i_clk);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic signed [wfm_pkg::SAMPLE_W-1:0] with_sign(int unsigned mag);
        logic signed [wfm_pkg::SAMPLE_W-1:0] v;
        if (mag >= 32768) return 16'sh8000;
        v = wfm_pkg::SAMPLE_W'(mag);
        return ($urandom_range(0, 1) == 1) ? -v : v;
    endfunction

    // Mostly well-formed wheel histories on an advancing clock; some noise and resets
    function automatic wfm_pkg::t_in_item next_random_item();
        logic signed [wfm_pkg::SAMPLE_W-1:0] tg [wfm_pkg::WHEELS];
        logic signed [wfm_pkg::SAMPLE_W-1:0] sp [wfm_pkg::WHEELS];
        int unsigned nz, ra, ac, st, step_max, roll, tm, sm;
        logic [wfm_pkg::REASON_W-1:0] kind;
        wfm_pkg::t_in_item item;
        nz = shadow_settings.target_near_zero;
        ra = shadow_settings.speed_runaway;
        ac = shadow_settings.target_active;
        st = shadow_settings.speed_stuck;
        step_max = shadow_settings.suspect_ms / 3 + shadow_settings.clear_ms / 6 + 2;
        roll = $urandom_range(0, 99);
        item.op = (roll < 2) ? wfm_pkg::OP_RESET : wfm_pkg::OP_UPDATE;
        if (roll < 10) begin
            for (int i = 0; i < wfm_pkg::WHEELS; i++) begin
                tg[i] = wfm_pkg::SAMPLE_W'($urandom);
                sp[i] = wfm_pkg::SAMPLE_W'($urandom);
            end
            if (roll < 5) sim_now = $urandom;
        end else begin
            sim_now += $urandom_range(0, step_max);
            for (int i = 0; i < wfm_pkg::WHEELS; i++) begin
                if ($urandom_range(0, wheel_bad[i] ? 9 : 5) == 0) begin
                    wheel_bad[i]  = !wheel_bad[i];
                    wheel_kind[i] = $urandom_range(0, 1) ? wfm_pkg::REASON_RUNAWAY
                                                         : wfm_pkg::REASON_STUCK;
                end
                kind = wheel_kind[i];
                if (kind == wfm_pkg::REASON_RUNAWAY && nz == 0) kind = wfm_pkg::REASON_STUCK;
                if (kind == wfm_pkg::REASON_STUCK && st == 0) begin
                    kind = (nz != 0) ? wfm_pkg::REASON_RUNAWAY : wfm_pkg::REASON_NONE;
                end
                if (!wheel_bad[i] || kind == wfm_pkg::REASON_NONE) begin
                    tm = $urandom_range(0, 32768);
                    sm = $urandom_range(0, 32768);
                    // sit right on the stop threshold now and then
                    if ($urandom_range(0, 3) == 0) tm = nz;
                end else if (kind == wfm_pkg::REASON_RUNAWAY) begin
                    tm = $urandom_range(0, nz - 1);
                    sm = $urandom_range(ra + 1, 32768);
                end else begin
                    tm = $urandom_range(ac + 1, 32768);
                    sm = $urandom_range(0, st - 1);
                end
                tg[i] = with_sign(tm);
                sp[i] = with_sign(sm);
            end
        end
        item.now_ms    = sim_now;
        item.target_fl = tg[0];
        item.target_rl = tg[1];
        item.target_fr = tg[2];
        item.target_rr = tg[3];
        item.speed_fl  = sp[0];
        item.speed_rl  = sp[1];
        item.speed_fr  = sp[2];
        item.speed_rr  = sp[3];
        return item;
    endfunction

    task automatic test_field_extremes();
        send_samples(wfm_pkg::OP_UPDATE, 32'h0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_samples(wfm_pkg::OP_UPDATE, 32'hFFFF_FF00, 32767, 32767, 32767, 32767,
                     -32768, -32768, -32768, -32768);
        // all wheels stuck, suspect window straddling the timer wrap
        send_samples(wfm_pkg::OP_UPDATE, 32'hFFFF_FF00, -32768, -32768, -32768, -32768,
                     0, 0, 0, 0);
        send_samples(wfm_pkg::OP_UPDATE, 32'h0000_00F3, -32768, -32768, -32768, -32768,
                     0, 0, 0, 0);
        send_samples(wfm_pkg::OP_UPDATE, 32'h0000_00F4, 32767, 32767, 32767, 32767,
                     127, -127, 1, -1);
        send_samples(wfm_pkg::OP_UPDATE, 32'h1000, -2000, -2000, -2000, -2000, 0, 0, 0, 0);
        send_samples(wfm_pkg::OP_UPDATE, 32'h1000 + 1999, 0, 0, 0, 0, 0, 0, 0, 0);
        send_samples(wfm_pkg::OP_UPDATE, 32'h1000 + 2000, 0, 0, 0, 0, 0, 0, 0, 0);
        // mixed runaway and stuck, with one wheel exactly on the runaway threshold
        send_samples(wfm_pkg::OP_UPDATE, 10000, 127, -127, 0, 1025, 2049, -2049, 2048, -127);
        send_samples(wfm_pkg::OP_UPDATE, 10100, 0, -127, 0, 1025, 0, -2049, 0, -127);
        send_samples(wfm_pkg::OP_UPDATE, 10500, 127, -127, 0, -1025, 32767, -32768, 0, -127);
        send_samples(wfm_pkg::OP_RESET, 10600, 127, -127, 0, 1025, 32767, -32768, 0, 0);
        send_samples(wfm_pkg::OP_UPDATE, 20000, 0, 0, -1, 0, 0, 0, -32768, 0);
        send_samples(wfm_pkg::OP_UPDATE, 20500, 0, 0, 1, 0, 0, 0, 32767, 0);
        send_samples(wfm_pkg::OP_RESET, 20600, 0, 0, 0, 0, 0, 0, 0, 0);
    endtask

    task automatic test_register_extremes();
        wait_drained();
        // samples both stopped and moving: runaway must win
        write_registers('{16'd1, 16'd32767, 16'd0, 16'd0, 16'd32767, 16'd0, 16'd0}, 1'b1);
        send_samples(wfm_pkg::OP_UPDATE, 100, 5, 5, 5, 5, 100, 100, 100, 100);
        send_samples(wfm_pkg::OP_UPDATE, 100, 5, -5, 5, -5, 100, -100, 100, -100);
        send_samples(wfm_pkg::OP_UPDATE, 100, 0, 0, 0, 0, 0, 0, 0, 0);
        send_samples(wfm_pkg::OP_UPDATE, 7, -32768, -32768, -32768, -32768,
                     -32768, -32768, -32768, -32768);
        send_samples(wfm_pkg::OP_UPDATE, 8, 32767, -32767, 0, 0, 32767, 1, 0, 0);
        wait_drained();
        write_registers('{16'd1, 16'd0, 16'd32767, 16'd32767, 16'd0, 16'hFFFF, 16'hFFFF},
                        1'b0);
        send_samples(wfm_pkg::OP_UPDATE, 0, -32768, -32768, -32768, -32768,
                     -32768, -32768, -32768, -32768);
        send_samples(wfm_pkg::OP_UPDATE, 0, 32767, 32767, 32767, 32767, 0, 0, 0, 0);
        wait_drained();
        // longest suspect and clear windows across the timer wrap
        write_registers('{16'd1, 16'd128, 16'd2048, 16'd1024, 16'd128, 16'hFFFF, 16'hFFFF},
                        1'b0);
        send_samples(wfm_pkg::OP_UPDATE, 32'hFFFF_0000, 0, 0, -32768, 0, 32767, 0, -127, 0);
        send_samples(wfm_pkg::OP_UPDATE, 32'hFFFF_FFFE, 0, 0, -32768, 0, 32767, 0, -127, 0);
        send_samples(wfm_pkg::OP_UPDATE, 32'hFFFF_FFFF, 0, 0, -32768, 0, 32767, 0, -127, 0);
        send_samples(wfm_pkg::OP_UPDATE, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0, 0);
        send_samples(wfm_pkg::OP_UPDATE, 32'h0000_FFFE, 0, 0, 0, 0, 0, 0, 0, 0);
    endtask

    task automatic test_monitor_disable();
        wait_drained();
        write_registers('{16'd1, 16'd128, 16'd2048, 16'd1024, 16'd128, 16'd500, 16'd2000},
                        1'b0);
        send_samples(wfm_pkg::OP_UPDATE, 1000, 2000, 0, 0, 0, 0, 0, 0, 0);
        send_samples(wfm_pkg::OP_UPDATE, 1500, 2000, 0, 0, 0, 0, 0, 0, 0);
        wait_drained();
        // frozen: samples ignored, state still reported
        write_registers('{16'd0, 16'd128, 16'd2048, 16'd1024, 16'd128, 16'd500, 16'd2000},
                        1'b0);
        send_samples(wfm_pkg::OP_UPDATE, 5000, 0, 0, 0, 0, 0, 0, 0, 0);
        send_samples(wfm_pkg::OP_UPDATE, 9000, 0, 0, 0, 0, 30000, 30000, 30000, 30000);
        send_samples(wfm_pkg::OP_RESET, 9100, 0, 0, 0, 0, 30000, 30000, 30000, 30000);
        send_samples(wfm_pkg::OP_UPDATE, 9500, 0, 0, 0, 0, 30000, 30000, 30000, 30000);
    endtask

    task automatic write_random_settings();
        logic [wfm_pkg::VALUE_W-1:0] vals [REG_COUNT];
        vals[0] = 16'd1;
        case ($urandom_range(0, 2))
            0: begin
                vals[1] = wfm_pkg::VALUE_W'($urandom_range(1, 512));
                vals[2] = wfm_pkg::VALUE_W'($urandom_range(256, 8192));
                vals[3] = wfm_pkg::VALUE_W'($urandom_range(256, 8192));
                vals[4] = wfm_pkg::VALUE_W'($urandom_range(1, 512));
            end
            1: begin
                // top bit lands outside the 15-bit thresholds
                for (int k = 1; k <= 4; k++) vals[k] = wfm_pkg::VALUE_W'($urandom);
            end
            default: begin
                for (int k = 1; k <= 4; k++) begin
                    case ($urandom_range(0, 2))
                        0:       vals[k] = 16'd0;
                        1:       vals[k] = 16'h7FFF;
                        default: vals[k] = wfm_pkg::VALUE_W'($urandom_range(0, 32767));
                    endcase
                end
            end
        endcase
        vals[5] = ($urandom_range(0, 7) == 0) ? 16'hFFFF
                                              : wfm_pkg::VALUE_W'($urandom_range(0, 2500));
        vals[6] = ($urandom_range(0, 7) == 0) ? 16'hFFFF
                                              : wfm_pkg::VALUE_W'($urandom_range(0, 5000));
        write_registers(vals, $urandom_range(0, 3) == 0);
    endtask

    task automatic test_backpressure();
        wait_drained();
        write_registers('{16'd1, 16'd128, 16'd2048, 16'd1024, 16'd128, 16'd500, 16'd2000},
                        1'b0);
        sim_now = $urandom;
        gaps_enabled = 1'b0;
        hold_cycles_req = 150;
        repeat (50) send_item(next_random_item());
        gaps_enabled = 1'b1;
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 6; phase++) begin
            wait_drained();
            write_random_settings();
            sim_now = (phase == 2) ? 32'hFFFF_8000 : $urandom;
            for (int i = 0; i < wfm_pkg::WHEELS; i++) wheel_bad[i] = 1'b0;
            gaps_enabled = (phase % 3 != 1);
            repeat (150) send_item(next_random_item());
        end
    endtask

    initial begin
        mismatch_count  = 0;
        burst_left      = 0;
        gaps_enabled    = 1'b1;
        hold_cycles_req = 0;
        sim_now         = '0;
        for (int i = 0; i < wfm_pkg::WHEELS; i++) begin
            wheel_bad[i]  = 1'b0;
            wheel_kind[i] = wfm_pkg::REASON_RUNAWAY;
        end
        clear_wheels();
        shadow_settings = '{enable: wfm_pkg::RST_MONITOR_ENABLE,
                            target_near_zero: wfm_pkg::RST_TARGET_NEAR_ZERO,
                            speed_runaway: wfm_pkg::RST_SPEED_RUNAWAY,
                            target_active: wfm_pkg::RST_TARGET_ACTIVE,
                            speed_stuck: wfm_pkg::RST_SPEED_STUCK,
                            suspect_ms: wfm_pkg::RST_SUSPECT_MS,
                            clear_ms: wfm_pkg::RST_CLEAR_MS};
        i_rst_n      <= 1'b0;
        in_ch.valid  <= 1'b0;
        in_ch.data   <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.data  <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_field_extremes();
        test_register_extremes();
        test_monitor_disable();
        test_backpressure();
        test_random_traffic();
        wait_drained();

        if (mismatch_count == 0 && awaited_status.size() == 0) begin
            $display("wheel_fault_monitor_tb: clean");
        end else begin
            $display("wheel_fault_monitor_tb: errors");
        end
        $finish;
    end

endmodule

### wheel_fault_monitor.f
+incdir+src
src/wfm_pkg.sv
src/wfm_chan_if.sv
src/wfm_lane.sv
src/wfm_merge.sv
src/wheel_fault_monitor.sv
test/wheel_fault_monitor_tb.sv
